@@ sv/xlsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the stripe accumulate block.
// No dependencies; used by every module of the block except xlsa_ram.
package xlsa_pkg;

   localparam int LANES             = 8;
   localparam int SECRET_WORDS      = 24;
   localparam int STRIPES_PER_BLOCK = 16;
   localparam int WORD_W            = 64;
   localparam int HALF_W            = 32;
   localparam int ADDR_W            = $clog2(SECRET_WORDS);
   localparam int CNT_W             = 4;
   localparam int KIND_W            = 3;
   localparam int SCRAMBLE_SHIFT    = 47;
   localparam int SCRAMBLE_KEY_BASE = 16;

   localparam logic [HALF_W-1:0] SCRAMBLE_PRIME = 32'd2654435761;

   localparam logic [KIND_W-1:0] KIND_SECRET = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STRIPE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TAIL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EMIT   = 3'd4;

   localparam logic [3:0] OP_NONE = 4'd0;
   localparam logic [3:0] OP_LOAD = 4'd1;
   localparam logic [3:0] OP_TAKE = 4'd2;
   localparam logic [3:0] OP_MUL  = 4'd3;
   localparam logic [3:0] OP_ACC  = 4'd4;
   localparam logic [3:0] OP_MIX  = 4'd5;
   localparam logic [3:0] OP_SLO  = 4'd6;
   localparam logic [3:0] OP_SHI  = 4'd7;
   localparam logic [3:0] OP_SEND = 4'd8;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [LANES-1:0][WORD_W-1:0] lane_words_type;

   typedef struct packed {
      logic [3:0]        op;
      logic              sec_we;
      logic [ADDR_W-1:0] sec_waddr;
      logic              rd_en;
   } lane_ctl_type;

endpackage

@@ sv/xlsa_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
// No dependencies.
module xlsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/xlsa_lane.sv @@
`timescale 1ns / 1ps
// One accumulator lane: private secret copy, one 32x32 multiplier, accumulator.
// Depends on xlsa_pkg and xlsa_ram.
module xlsa_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  xlsa_pkg::lane_ctl_type        ctl,
   input  xlsa_pkg::word_type            din,
   input  xlsa_pkg::word_type            sec_wdata,
   input  logic [xlsa_pkg::ADDR_W-1:0]   rd_addr,
   output xlsa_pkg::word_type            acc
);

   xlsa_pkg::word_type          rdata;
   xlsa_pkg::word_type          acc_ff, acc_in;
   xlsa_pkg::word_type          work_ff, work_in;
   logic [2*xlsa_pkg::HALF_W-1:0] prod_ff, prod_in;
   logic [xlsa_pkg::HALF_W-1:0] mul_a, mul_b;
   logic [2*xlsa_pkg::HALF_W-1:0] mul_p;
   xlsa_pkg::word_type          mixed;

   xlsa_ram #(.WIDTH(xlsa_pkg::WORD_W), .DEPTH(xlsa_pkg::SECRET_WORDS)) u_secret (
      .clock   (clock),
      .wr_en   (ctl.sec_we),
      .wr_addr (ctl.sec_waddr),
      .wr_data (sec_wdata),
      .rd_en   (ctl.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

   assign mixed = acc_ff ^ (acc_ff >> xlsa_pkg::SCRAMBLE_SHIFT) ^ rdata;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      acc_in  = acc_ff;
      work_in = work_ff;
      prod_in = prod_ff;
      mul_a   = work_ff[xlsa_pkg::HALF_W-1:0];
      mul_b   = xlsa_pkg::SCRAMBLE_PRIME;
      unique case (ctl.op)
         xlsa_pkg::OP_LOAD: begin
            acc_in = din;
         end
         xlsa_pkg::OP_TAKE: begin
            work_in = din;
         end
         xlsa_pkg::OP_MUL: begin
            mul_a   = work_ff[xlsa_pkg::HALF_W-1:0] + rdata[xlsa_pkg::HALF_W-1:0];
            mul_b   = work_ff[xlsa_pkg::WORD_W-1:xlsa_pkg::HALF_W]
                    + rdata[xlsa_pkg::WORD_W-1:xlsa_pkg::HALF_W];
            prod_in = mul_p;
         end
         xlsa_pkg::OP_ACC: begin
            acc_in = acc_ff + prod_ff + work_ff;
         end
         xlsa_pkg::OP_MIX: begin
            work_in = mixed;
         end
         xlsa_pkg::OP_SLO: begin
            prod_in = mul_p;
         end
         xlsa_pkg::OP_SHI: begin
            mul_a   = work_ff[xlsa_pkg::WORD_W-1:xlsa_pkg::HALF_W];
            prod_in = mul_p;
            acc_in  = prod_ff;
         end
         xlsa_pkg::OP_SEND: begin
            acc_in = acc_ff + {prod_ff[xlsa_pkg::HALF_W-1:0], {xlsa_pkg::HALF_W{1'b0}}};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      work_ff <= work_in;
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule

@@ sv/xlsa_merge.sv @@
`timescale 1ns / 1ps
// Output stage: gathers the eight lane accumulators into one result item.
// Depends on xlsa_pkg.
module xlsa_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  xlsa_pkg::lane_words_type lane_sum,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output xlsa_pkg::lane_words_type rsp_sum
);

   logic                     valid_ff, valid_in;
   xlsa_pkg::lane_words_type sum_ff, sum_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      sum_in   = sum_ff;
      if (load) begin
         valid_in = 1'b1;
         sum_in   = lane_sum;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      sum_ff <= sum_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_sum   = sum_ff;

endmodule

@@ sv/xxh3_long_stripe_accumulate_top.sv @@
`timescale 1ns / 1ps
// Top level of the long-input stripe accumulator: sequencer, eight lanes, output stage.
// Depends on xlsa_pkg, xlsa_lane, xlsa_merge.
//
// One item at a time. A secret-word load or accumulator load is done on accept.
// A stripe is accepted with the secret read, then forms one 32x32 product in
// each lane, then accumulates. The stripe that closes a block of 16 stripes
// then runs the scramble (key read and mix, low and high products through the
// same lane multiplier, final add). Tail and emit items then load the output
// register, waiting while an earlier result still sits there; later items are
// taken while a result waits. Every lane keeps its own copy of the secret so
// all eight read in the same cycle.
module xxh3_long_stripe_accumulate_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [xlsa_pkg::KIND_W-1:0]         req_kind,
   input  logic [xlsa_pkg::ADDR_W-1:0]         req_word_index,
   input  logic [63:0]                         req_lane_0,
   input  logic [63:0]                         req_lane_1,
   input  logic [63:0]                         req_lane_2,
   input  logic [63:0]                         req_lane_3,
   input  logic [63:0]                         req_lane_4,
   input  logic [63:0]                         req_lane_5,
   input  logic [63:0]                         req_lane_6,
   input  logic [63:0]                         req_lane_7,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [63:0]                         rsp_sum_0,
   output logic [63:0]                         rsp_sum_1,
   output logic [63:0]                         rsp_sum_2,
   output logic [63:0]                         rsp_sum_3,
   output logic [63:0]                         rsp_sum_4,
   output logic [63:0]                         rsp_sum_5,
   output logic [63:0]                         rsp_sum_6,
   output logic [63:0]                         rsp_sum_7
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_MIX  = 3'd3;
   localparam logic [2:0] ST_SLO  = 3'd4;
   localparam logic [2:0] ST_SHI  = 3'd5;
   localparam logic [2:0] ST_SEND = 3'd6;
   localparam logic [2:0] ST_EMIT = 3'd7;

   logic [2:0]                   state_ff, state_in;
   logic [xlsa_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         tail_ff, tail_in;
   logic [xlsa_pkg::CNT_W:0]     cnt_next;
   logic                         wrap;
   logic                         accept;
   logic                         scr_phase;
   logic                         out_load;
   logic                         out_free;
   xlsa_pkg::lane_ctl_type       ctl;
   xlsa_pkg::lane_words_type     req_lane;
   xlsa_pkg::lane_words_type     lane_sum;
   xlsa_pkg::lane_words_type     rsp_sum;

   assign req_lane[0] = req_lane_0;
   assign req_lane[1] = req_lane_1;
   assign req_lane[2] = req_lane_2;
   assign req_lane[3] = req_lane_3;
   assign req_lane[4] = req_lane_4;
   assign req_lane[5] = req_lane_5;
   assign req_lane[6] = req_lane_6;
   assign req_lane[7] = req_lane_7;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign scr_phase = (state_ff == ST_ACC);
   assign cnt_next  = {1'b0, cnt_ff} + 5'd1;
   assign wrap      = (cnt_next >= 5'(xlsa_pkg::STRIPES_PER_BLOCK))
                   || (cnt_next[xlsa_pkg::CNT_W-1:0] == '0);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tail_in       = tail_ff;
      out_load      = 1'b0;
      ctl.op        = xlsa_pkg::OP_NONE;
      ctl.sec_we    = 1'b0;
      ctl.sec_waddr = req_word_index;
      ctl.rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind) inside
                  xlsa_pkg::KIND_SECRET: begin
                     ctl.sec_we = (req_word_index < 5'(xlsa_pkg::SECRET_WORDS));
                  end
                  xlsa_pkg::KIND_LOAD: begin
                     ctl.op = xlsa_pkg::OP_LOAD;
                     cnt_in = '0;
                  end
                  xlsa_pkg::KIND_STRIPE, xlsa_pkg::KIND_TAIL: begin
                     ctl.op    = xlsa_pkg::OP_TAKE;
                     ctl.rd_en = 1'b1;
                     tail_in   = (req_kind == xlsa_pkg::KIND_TAIL);
                     state_in  = ST_MUL;
                  end
                  xlsa_pkg::KIND_EMIT: begin
                     state_in = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MUL: begin
            ctl.op   = xlsa_pkg::OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            ctl.op = xlsa_pkg::OP_ACC;
            if (tail_ff) begin
               state_in = ST_EMIT;
            end else if (wrap) begin
               ctl.rd_en = 1'b1;
               cnt_in    = '0;
               state_in  = ST_MIX;
            end else begin
               cnt_in   = cnt_next[xlsa_pkg::CNT_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_MIX: begin
            ctl.op   = xlsa_pkg::OP_MIX;
            state_in = ST_SLO;
         end
         ST_SLO: begin
            ctl.op   = xlsa_pkg::OP_SLO;
            state_in = ST_SHI;
         end
         ST_SHI: begin
            ctl.op   = xlsa_pkg::OP_SHI;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            ctl.op   = xlsa_pkg::OP_SEND;
            state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         tail_ff  <= tail_in;
      end
   end

   for (genvar g = 0; g < xlsa_pkg::LANES; g++) begin : g_lane
      logic [xlsa_pkg::ADDR_W-1:0] rd_addr;

      assign rd_addr = scr_phase
                     ? xlsa_pkg::ADDR_W'(xlsa_pkg::SCRAMBLE_KEY_BASE + g)
                     : xlsa_pkg::ADDR_W'({1'b0, cnt_ff}) + xlsa_pkg::ADDR_W'(g);

      xlsa_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .din       (req_lane[g]),
         .sec_wdata (req_lane_0),
         .rd_addr   (rd_addr),
         .acc       (lane_sum[g])
      );
   end

   xlsa_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .lane_sum  (lane_sum),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_sum   (rsp_sum)
   );

   assign rsp_sum_0 = rsp_sum[0];
   assign rsp_sum_1 = rsp_sum[1];
   assign rsp_sum_2 = rsp_sum[2];
   assign rsp_sum_3 = rsp_sum[3];
   assign rsp_sum_4 = rsp_sum[4];
   assign rsp_sum_5 = rsp_sum[5];
   assign rsp_sum_6 = rsp_sum[6];
   assign rsp_sum_7 = rsp_sum[7];

   a_emit_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == xlsa_pkg::KIND_EMIT) |=> (state_ff == ST_EMIT))
      else $error("emit item did not reach the output step");

   a_scramble_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |=> (cnt_ff == '0))
      else $error("stripe count not cleared after scramble");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid)
      else $error("result not presented after output load");

   a_tail_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC && tail_ff) |=> (state_ff == ST_EMIT && $stable(cnt_ff)))
      else $error("tail stripe changed the count or skipped emit");

endmodule
